@@ hdl/binary_morphology_row_filter_macros.svh @@
// Assertion helpers for the checker of this block.
`ifndef BINARY_MORPHOLOGY_ROW_FILTER_MACROS_SVH
`define BINARY_MORPHOLOGY_ROW_FILTER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define BMRF_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define BMRF_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ hdl/bmrf_pkg.sv @@
package bmrf_pkg;

   localparam int ROW_W          = 64;
   localparam int MASK_W         = 49;
   localparam int KERNEL_STRIDE  = 7;
   localparam int SEEN_W         = 3;
   localparam int DIST_W         = 2;
   localparam logic [SEEN_W-1:0] SEEN_MAX = 3'd7;

   localparam logic [2:0] CSR_KERNEL_MASK   = 3'd0;
   localparam logic [2:0] CSR_KERNEL_WIDTH  = 3'd1;
   localparam logic [2:0] CSR_KERNEL_HEIGHT = 3'd2;
   localparam logic [2:0] CSR_IMAGE_WIDTH   = 3'd3;
   localparam logic [2:0] CSR_MODE          = 3'd4;

   localparam logic MODE_DILATE = 1'b1;

   typedef struct packed {
      logic [ROW_W-1:0] row_bits;
      logic             last_row;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0] result_row;
      logic             frame_end;
   } rsp_type;

   typedef struct packed {
      logic [MASK_W-1:0] kernel_mask;
      logic [2:0]        kernel_width;
      logic [2:0]        kernel_height;
      logic [6:0]        image_width;
      logic              mode;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      kernel_mask:   '0,
      kernel_width:  3'd3,
      kernel_height: 3'd3,
      image_width:   7'd64,
      mode:          1'b0
   };

   // Zero acts as one, anything above the supported size saturates.
   function automatic logic [2:0] clamp_kernel(input logic [2:0] v, input logic [2:0] maxk);
      logic [2:0] r;
      if (v == 3'd0) begin
         r = 3'd1;
      end else if (v > maxk) begin
         r = maxk;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Ones on the pixels that lie inside the image.
   function automatic logic [ROW_W-1:0] width_mask(input logic [6:0] iw, input logic [6:0] maxw);
      logic [ROW_W-1:0] m;
      logic [6:0]       w;
      w = (iw > maxw) ? maxw : iw;
      for (int x = 0; x < ROW_W; x++) begin
         m[x] = (7'(x) < w);
      end
      return m;
   endfunction

endpackage

@@ hdl/bmrf_window.sv @@
module bmrf_window import bmrf_pkg::*; #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_KERNEL = 7
) (
   input  logic [MAX_WIDTH-1:0] taps [MAX_KERNEL],
   input  logic [DIST_W-1:0]    job_d,
   input  logic [SEEN_W-1:0]    job_n,
   input  cfg_type              cfg,
   output logic [MAX_WIDTH-1:0] result
);

   localparam int HALF = MAX_KERNEL / 2;

   function automatic logic [MAX_WIDTH-1:0] shift_take(input logic [MAX_WIDTH-1:0] v,
                                                       input int s);
      logic [MAX_WIDTH-1:0] r;
      if (s >= 0) begin
         r = v >> s;
      end else begin
         r = v << (-s);
      end
      return r;
   endfunction

   always_comb begin
      logic [2:0]           kw;
      logic [2:0]           kh;
      logic [1:0]           cx;
      logic [1:0]           cy;
      logic [ROW_W-1:0]     wm_full;
      logic [MAX_WIDTH-1:0] wm;
      logic [MAX_WIDTH-1:0] acc;
      logic [MAX_WIDTH-1:0] row;
      logic                 dil;
      logic                 use_row;
      logic                 en;
      logic [5:0]           idx;
      int                   v;
      int                   s;
      int                   back;
      int                   ky;
      int                   kx;

      kw      = clamp_kernel(cfg.kernel_width, 3'(MAX_KERNEL));
      kh      = clamp_kernel(cfg.kernel_height, 3'(MAX_KERNEL));
      cx      = kw[2:1];
      cy      = kh[2:1];
      wm_full = width_mask(cfg.image_width, 7'(MAX_WIDTH));
      wm      = wm_full[MAX_WIDTH-1:0];
      dil     = (cfg.mode == MODE_DILATE);
      acc     = dil ? '0 : '1;

      for (int vi = 0; vi <= 2 * HALF; vi++) begin
         v    = vi - HALF;
         back = int'(job_d) - v;
         use_row = (back >= 0) && (back < int'(job_n));
         // pick the row that arrived 'back' rows before the newest
         row = '0;
         for (int k = 0; k < MAX_KERNEL; k++) begin
            if (back == k) begin
               row = taps[k] & wm;
            end
         end
         for (int si = 0; si <= 2 * HALF; si++) begin
            s = si - HALF;
            if (dil) begin
               ky = int'(cy) - v;
               kx = int'(cx) - s;
            end else begin
               ky = v + int'(cy);
               kx = s + int'(cx);
            end
            en  = (ky >= 0) && (ky < int'(kh)) && (kx >= 0) && (kx < int'(kw));
            idx = en ? 6'(ky * KERNEL_STRIDE + kx) : 6'd0;
            if (en && use_row && cfg.kernel_mask[idx]) begin
               if (dil) begin
                  acc = acc | shift_take(row, s);
               end else begin
                  acc = acc & (shift_take(row, s) | ~shift_take(wm, s));
               end
            end
         end
      end
      result = acc & wm;
   end

endmodule

@@ hdl/binary_morphology_row_filter.sv @@
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    req_type: row_bits, last_row
// rsp      out        rsp_valid/rsp_ready    rsp_type: result_row, frame_end
// csr      in         csr_valid/csr_ready    csr_index, csr_wdata (always ready)
//
// One row beat is taken per cycle while req_ready is high; results pass through
// the pending-row and result registers. A last row holds req_ready low while the
// flush still owes rows (up to floor(h/2)), one per cycle unless rsp is stalled.
// Synchronous reset clears control and restores the register defaults; no
// clearing pass. A stalled result beat holds its payload; input keeps flowing
// while the single pending-row slot is free.
module binary_morphology_row_filter import bmrf_pkg::*; #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_KERNEL = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [ROW_W-1:0] csr_wdata
);

   // configuration registers
   cfg_type cfg_ff;
   cfg_type cfg_in;

   // line store as a shift line, tap 0 holds the newest row
   logic [MAX_WIDTH-1:0] taps_ff [MAX_KERNEL];
   logic [MAX_WIDTH-1:0] taps_in [MAX_KERNEL];

   logic [SEEN_W-1:0] seen_ff, seen_in;

   // pending row to compute: distance back from newest, rows held, flush flag
   logic              job_valid_ff, job_valid_in;
   logic [DIST_W-1:0] job_d_ff, job_d_in;
   logic [SEEN_W-1:0] job_n_ff, job_n_in;
   logic              job_last_ff, job_last_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff, rsp_payload_in;

   logic                 out_free;
   logic                 consume;
   logic                 accept;
   logic [2:0]           kh_c;
   logic [DIST_W-1:0]    cy;
   logic [SEEN_W-1:0]    n_new;
   logic [ROW_W-1:0]     store_mask_full;
   logic [MAX_WIDTH-1:0] store_mask;
   logic [MAX_WIDTH-1:0] win_row;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign consume   = job_valid_ff && out_free;
   // take a row only when the pending slot is empty or empties without more flush work
   assign req_ready = !job_valid_ff
                      || (out_free && !(job_last_ff && (job_d_ff != '0)));
   assign accept    = req_valid && req_ready;

   assign kh_c            = clamp_kernel(cfg_ff.kernel_height, 3'(MAX_KERNEL));
   assign cy              = kh_c[2:1];
   assign n_new           = (seen_ff == SEEN_MAX) ? SEEN_MAX : seen_ff + 3'd1;
   assign store_mask_full = width_mask(cfg_ff.image_width, 7'(MAX_WIDTH));
   assign store_mask      = store_mask_full[MAX_WIDTH-1:0];

   bmrf_window #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_KERNEL (MAX_KERNEL)
   ) u_window (
      .taps   (taps_ff),
      .job_d  (job_d_ff),
      .job_n  (job_n_ff),
      .cfg    (cfg_ff),
      .result (win_row)
   );

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_KERNEL_MASK:   cfg_in.kernel_mask   = csr_wdata[MASK_W-1:0];
            CSR_KERNEL_WIDTH:  cfg_in.kernel_width  = csr_wdata[2:0];
            CSR_KERNEL_HEIGHT: cfg_in.kernel_height = csr_wdata[2:0];
            CSR_IMAGE_WIDTH:   cfg_in.image_width   = csr_wdata[6:0];
            CSR_MODE:          cfg_in.mode          = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // line store, frame row count and pending-row control
   always_comb begin
      taps_in      = taps_ff;
      seen_in      = seen_ff;
      job_valid_in = job_valid_ff;
      job_d_in     = job_d_ff;
      job_n_in     = job_n_ff;
      job_last_in  = job_last_ff;

      if (consume) begin
         // step down through the flush, otherwise drop the finished row
         if (job_last_ff && (job_d_ff != '0)) begin
            job_d_in = job_d_ff - 2'd1;
         end else begin
            job_valid_in = 1'b0;
         end
      end

      if (accept) begin
         taps_in[0] = req_payload.row_bits[MAX_WIDTH-1:0] & store_mask;
         for (int k = 1; k < MAX_KERNEL; k++) begin
            taps_in[k] = taps_ff[k-1];
         end
         job_n_in = n_new;
         if (req_payload.last_row) begin
            // flush every row still owed, oldest first; restart the frame
            job_valid_in = 1'b1;
            job_last_in  = 1'b1;
            job_d_in     = ({1'b0, cy} < n_new) ? cy : DIST_W'(n_new - 3'd1);
            seen_in      = '0;
         end else begin
            job_valid_in = ({1'b0, cy} < n_new);
            job_last_in  = 1'b0;
            job_d_in     = cy;
            seen_in      = n_new;
         end
      end
   end

   // result register: load when empty or being taken
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (out_free) begin
         rsp_valid_in              = job_valid_ff;
         rsp_payload_in.result_row = ROW_W'(win_row);
         rsp_payload_in.frame_end  = job_last_ff && (job_d_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         seen_ff      <= '0;
         job_valid_ff <= 1'b0;
         job_last_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         seen_ff      <= seen_in;
         job_valid_ff <= job_valid_in;
         job_last_ff  <= job_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      taps_ff        <= taps_in;
      job_d_ff       <= job_d_in;
      job_n_ff       <= job_n_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ hdl/bmrf_checker.sv @@
`include "binary_morphology_row_filter_macros.svh"

module bmrf_checker import bmrf_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // reset empties the pipe: nothing to show, room for a row
   `BMRF_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, req_ready && !rsp_valid, "reset did not empty the pipe")

   // a stalled result beat stays and holds its payload
   `BMRF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled result beat changed")

   // a last row always leaves a row pending; with the output stalled, no new row
   `BMRF_ASSERT_IMPLY(a_flush_blocks, clock, reset, $past(req_valid && req_ready && req_payload.last_row) && !$past(reset) && rsp_valid && !rsp_ready, !req_ready, "row taken over a pending flush")

endmodule

bind binary_morphology_row_filter bmrf_checker u_bmrf_checker (.*);
